>>> design/sync_packet_receiver_fletcher_unit_macros.svh
// assertion macros used by the checker file
`ifndef SYNC_PACKET_RECEIVER_FLETCHER_UNIT_MACROS_SVH
`define SYNC_PACKET_RECEIVER_FLETCHER_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define SPRF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprf assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define SPRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprf assertion failed");

`endif

>>> design/sprf_pkg.sv
`default_nettype none

package sprf_pkg;

   // packet geometry
   localparam int PACKET_BYTES = 16;
   localparam int ADDR_W       = $clog2(PACKET_BYTES);
   localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
   localparam int EMIT_LEN     = PACKET_BYTES - 2;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int TICK_W   = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   typedef logic [STATUS_W-1:0] status_type;

   // result status codes
   localparam status_type STATUS_OK  = 2'd0;
   localparam status_type STATUS_DUP = 2'd1;
   localparam status_type STATUS_BAD = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'd1;

   // reset values
   localparam logic [BYTE_W-1:0] RESET_SYNC    = 8'd0;
   localparam logic [TICK_W-1:0] RESET_TIMEOUT = 16'd100;
   localparam logic [BYTE_W-1:0] RESET_SEQ     = 8'hAA;

endpackage

`default_nettype wire

>>> design/sprf_ram.sv
`default_nettype none

module sprf_ram
   import sprf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [PACKET_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/sync_packet_receiver_fletcher_unit.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_action, req_rx_byte
// rsp       out        rsp_valid/rsp_stall   rsp_status, rsp_byte_index, rsp_byte_value, rsp_last
// csr       in         csr_write             csr_index, csr_data
//
// ticks and bytes are taken one per cycle unless req stalls, also a byte that completes a packet.
// an accepted packet then streams PACKET_BYTES-2 results after a registered packet store read,
// one per cycle unless rsp stalls; the single read port sets that rate. req is stalled meanwhile.
// a completing byte is stalled while the result register is still full.
// synchronous reset: control and csr registers reset; data registers and the store need no pass.
`default_nettype none

module sync_packet_receiver_fletcher_unit
   import sprf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_action,
   input  wire logic [BYTE_W-1:0]    req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [STATUS_W-1:0]  rsp_status,
   output logic      [INDEX_W-1:0]   rsp_byte_index,
   output logic      [BYTE_W-1:0]    rsp_byte_value,
   output logic                      rsp_last,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data
);

   typedef enum logic {ST_RUN, ST_EMIT} state_type;

   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(PACKET_BYTES - 1);
   localparam logic [CNT_W-1:0] CHK_POS  = CNT_W'(PACKET_BYTES - 2);
   localparam logic [CNT_W-1:0] SEQ_POS  = CNT_W'(1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PACKET_BYTES);
   localparam logic [CNT_W-1:0] EMIT_CNT = CNT_W'(EMIT_LEN);
   localparam logic [ADDR_W-1:0] EMIT_LAST = ADDR_W'(EMIT_LEN - 1);

   // one step of a sum modulo 255, both operands already reduced or a raw byte
   function automatic logic [BYTE_W-1:0] add_mod255(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
      logic [BYTE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 9'd255) begin
         s = s - 9'd255;
      end
      return s[BYTE_W-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic              collecting_ff, collecting_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [BYTE_W-1:0] sum1_ff, sum1_in;
   logic [BYTE_W-1:0] sum2_ff, sum2_in;
   logic [TICK_W-1:0] idle_ff, idle_in;
   logic [BYTE_W-1:0] acc_seq_ff, acc_seq_in;
   logic [BYTE_W-1:0] seq_ff, seq_in;
   logic [BYTE_W-1:0] chk_lo_ff, chk_lo_in;
   logic [BYTE_W-1:0] sync_ff, sync_in;
   logic [TICK_W-1:0] timeout_ff, timeout_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              mem_valid_ff, mem_valid_in;
   logic [ADDR_W-1:0] mem_idx_ff, mem_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [BYTE_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_xfer;
   logic              out_free;
   logic              move;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [BYTE_W-1:0] rd_data;
   logic [BYTE_W-1:0] s1_next;
   logic [BYTE_W-1:0] s2_next;
   logic [BYTE_W-1:0] s1_sync;
   logic [TICK_W-1:0] idle_inc;

   // packet store
   sprf_ram u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // handshake terms
   assign req_stall = (state_ff != ST_RUN) ||
                      (rsp_valid_ff && collecting_ff && (fill_ff == LAST_POS));
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = (state_ff == ST_EMIT) && mem_valid_ff && out_free;

   // running sums and saturating idle count
   assign s1_next  = add_mod255(sum1_ff, req_rx_byte);
   assign s2_next  = add_mod255(sum2_ff, s1_next);
   assign s1_sync  = add_mod255(8'd0, req_rx_byte);
   assign idle_inc = (idle_ff == {TICK_W{1'b1}}) ? idle_ff : idle_ff + 16'd1;

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      collecting_in = collecting_ff;
      fill_in       = fill_ff;
      sum1_in       = sum1_ff;
      sum2_in       = sum2_ff;
      idle_in       = idle_ff;
      acc_seq_in    = acc_seq_ff;
      seq_in        = seq_ff;
      chk_lo_in     = chk_lo_ff;
      sync_in       = sync_ff;
      timeout_in    = timeout_ff;
      rd_cnt_in     = rd_cnt_ff;
      mem_valid_in  = mem_valid_ff;
      mem_idx_in    = mem_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[ADDR_W-1:0];
      rd_en         = 1'b0;

      // register writes
      if (csr_write) begin
         case (csr_index)
            CSR_SYNC:    sync_in    = csr_data[BYTE_W-1:0];
            CSR_TIMEOUT: timeout_in = csr_data;
            default:     sync_in    = sync_ff;
         endcase
      end

      case (state_ff)
         ST_RUN: begin
            if (req_xfer) begin
               if (!req_action) begin
                  // idle tick, may drop a partial packet
                  idle_in = idle_inc;
                  if (idle_inc > timeout_ff) begin
                     collecting_in = 1'b0;
                     fill_in       = '0;
                  end
               end else if (!collecting_ff) begin
                  // hunt for the sync byte
                  if (req_rx_byte == sync_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = '0;
                     sum1_in       = s1_sync;
                     sum2_in       = s1_sync;
                     fill_in       = CNT_W'(1);
                     idle_in       = '0;
                     collecting_in = 1'b1;
                  end
               end else begin
                  idle_in = '0;
                  if (fill_ff >= FULL_CNT) begin
                     collecting_in = 1'b0;
                     fill_in       = '0;
                  end else begin
                     wr_en = 1'b1;
                     if (fill_ff < CHK_POS) begin
                        sum1_in = s1_next;
                        sum2_in = s2_next;
                     end
                     if (fill_ff == SEQ_POS) begin
                        seq_in = req_rx_byte;
                     end
                     if (fill_ff == CHK_POS) begin
                        chk_lo_in = req_rx_byte;
                     end
                     if (fill_ff == LAST_POS) begin
                        // packet complete: judge it
                        collecting_in = 1'b0;
                        fill_in       = '0;
                        if (seq_ff == acc_seq_ff) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = STATUS_DUP;
                           rsp_index_in  = '0;
                           rsp_value_in  = '0;
                           rsp_last_in   = 1'b1;
                        end else if ({sum2_ff, sum1_ff} != {req_rx_byte, chk_lo_ff}) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = STATUS_BAD;
                           rsp_index_in  = '0;
                           rsp_value_in  = '0;
                           rsp_last_in   = 1'b1;
                        end else begin
                           acc_seq_in   = seq_ff;
                           state_in     = ST_EMIT;
                           rd_cnt_in    = '0;
                           mem_valid_in = 1'b0;
                        end
                     end else begin
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
               end
            end
         end
         ST_EMIT: begin
            // move read data into the result register
            if (move) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_index_in  = INDEX_W'(mem_idx_ff);
               rsp_value_in  = rd_data;
               rsp_last_in   = (mem_idx_ff == EMIT_LAST);
               if (mem_idx_ff == EMIT_LAST) begin
                  state_in = ST_RUN;
               end
            end
            // issue the next read when its data can be held
            if ((rd_cnt_ff != EMIT_CNT) && (!mem_valid_ff || move)) begin
               rd_en        = 1'b1;
               mem_valid_in = 1'b1;
               mem_idx_in   = rd_cnt_ff[ADDR_W-1:0];
               rd_cnt_in    = rd_cnt_ff + CNT_W'(1);
            end else if (move) begin
               mem_valid_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         collecting_ff <= 1'b0;
         fill_ff       <= '0;
         sum1_ff       <= '0;
         sum2_ff       <= '0;
         idle_ff       <= '0;
         acc_seq_ff    <= RESET_SEQ;
         sync_ff       <= RESET_SYNC;
         timeout_ff    <= RESET_TIMEOUT;
         rd_cnt_ff     <= '0;
         mem_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         collecting_ff <= collecting_in;
         fill_ff       <= fill_in;
         sum1_ff       <= sum1_in;
         sum2_ff       <= sum2_in;
         idle_ff       <= idle_in;
         acc_seq_ff    <= acc_seq_in;
         sync_ff       <= sync_in;
         timeout_ff    <= timeout_in;
         rd_cnt_ff     <= rd_cnt_in;
         mem_valid_ff  <= mem_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      seq_ff        <= seq_in;
      chk_lo_ff     <= chk_lo_in;
      mem_idx_ff    <= mem_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_byte_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

>>> design/sprf_checker.sv
`default_nettype none
`include "sync_packet_receiver_fletcher_unit_macros.svh"

module sprf_checker
   import sprf_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [INDEX_W-1:0]  rsp_byte_index,
   input wire logic [BYTE_W-1:0]   rsp_byte_value,
   input wire logic                rsp_last
);

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(EMIT_LEN - 1);

   // stalled result holds
   `SPRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_byte_index) && $stable(rsp_byte_value) && $stable(rsp_last))

   // a reject is a single zeroed result that closes the packet
   `SPRF_ASSERT_IMPL(a_reject_form, clock, reset, rsp_valid && (rsp_status != STATUS_OK), rsp_last && (rsp_byte_index == '0) && (rsp_byte_value == '0))

   // the closing byte of an accepted packet sits at the last data offset
   `SPRF_ASSERT_IMPL(a_last_index, clock, reset, rsp_valid && (rsp_status == STATUS_OK) && rsp_last, rsp_byte_index == LAST_INDEX)

   // input held off while a packet streams out
   `SPRF_ASSERT_IMPL(a_emit_stall, clock, reset, rsp_valid && (rsp_status == STATUS_OK) && !rsp_last, req_stall)

endmodule

bind sync_packet_receiver_fletcher_unit sprf_checker u_sprf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_byte_index (rsp_byte_index),
   .rsp_byte_value (rsp_byte_value),
   .rsp_last       (rsp_last)
);

`default_nettype wire
